// File: rtl/assert_macros.svh
// Assertion macros for the RTL, included by ray_triangle_intersect.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_DELAY(label, clk, rst, a, n, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> ##n (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, a, b)
`define ASSERT_DELAY(label, clk, rst, a, n, b)
`endif
`endif

// File: rtl/rti_pkg.sv
// Types and constants of the ray/triangle intersection pipeline.
package rti_pkg;

  localparam int CW = 32;            // coordinate width
  localparam int FB = 16;            // fraction bits
  localparam int BW = FB + 1;        // barycentric width
  localparam int EW = CW + 1;        // edges and origin offset
  localparam int PW = 2 * CW + 2;    // P = dir x E2
  localparam int QW = 2 * CW + 3;    // Q = T x E1
  localparam int SW = 3 * CW + 6;    // det, u, v, t
  localparam int QB = (CW > FB + 1) ? CW : FB + 1;  // quotient bits
  localparam int DW = SW + 1;        // divisor 2*det
  localparam int NW = SW + FB + 2;   // rounded numerator
  localparam int CFG_IDX_W = 3;

  localparam logic [CW-1:0] DIR_Z_RESET   = CW'(1) << FB;
  localparam logic [CW-1:0] DET_MIN_RESET = CW'(7);
  localparam logic [BW-1:0] BARY_ONE      = BW'(1) << FB;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORG_X, CFG_ORG_Y, CFG_ORG_Z,
    CFG_DIR_X, CFG_DIR_Y, CFG_DIR_Z,
    CFG_DET_MIN
  } cfg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] vert_a_x;
    logic signed [CW-1:0] vert_a_y;
    logic signed [CW-1:0] vert_a_z;
    logic signed [CW-1:0] vert_b_x;
    logic signed [CW-1:0] vert_b_y;
    logic signed [CW-1:0] vert_b_z;
    logic signed [CW-1:0] vert_c_x;
    logic signed [CW-1:0] vert_c_y;
    logic signed [CW-1:0] vert_c_z;
  } triangle_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] hit_distance;
    logic [BW-1:0]        bary_u;
    logic [BW-1:0]        bary_v;
  } result_t;

  typedef struct packed {
    logic hit;
    logic tneg;
  } div_side_t;

endpackage

// File: rtl/rti_mul.sv
// Two-stage signed multiplier, operand b split into two partial products.
module rti_mul #(
  parameter int AW = 33,
  parameter int BW = 66
) (
  input  logic                    clk,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);
  localparam int LW = BW / 2;
  localparam int HW = BW - LW;

  logic signed [AW+LW:0]   pl;
  logic signed [AW+HW-1:0] ph;

  always_ff @(posedge clk) begin
    pl <= a * $signed({1'b0, b[LW-1:0]});
    ph <= a * $signed(b[BW-1:LW]);
    p  <= ((AW+BW)'(ph) <<< LW) + (AW+BW)'(pl);
  end
endmodule

// File: rtl/rti_div.sv
// Pipelined restoring divider, three numerators over one shared divisor.
module rti_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  rti_pkg::div_side_t          in_side,
  input  logic [rti_pkg::NW-1:0]      num [3],
  input  logic [rti_pkg::DW-1:0]      den,
  output logic                        out_valid,
  output rti_pkg::div_side_t          out_side,
  output logic                        ovf,
  output logic [rti_pkg::QB-1:0]      quo [3]
);
  import rti_pkg::*;

  localparam int RW = ((NW > DW + QB) ? NW : DW + QB) + 1;

  logic [RW-1:0] rem  [QB+1][3];
  logic [QB-1:0] q    [QB+1][3];
  logic [DW-1:0] dd   [QB+1];
  logic          vld  [QB+1];
  logic          of   [QB+1];
  div_side_t     side [QB+1];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      rem[0][i] <= RW'(num[i]);
      q[0][i]   <= '0;
    end
    dd[0]   <= den;
    side[0] <= in_side;
    // lane 0 quotient does not fit in QB bits
    of[0]   <= RW'(num[0]) >= (RW'(den) << QB);
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_stage
    localparam int K = QB - s;
    logic [RW:0] diff [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        diff[i] = {1'b0, rem[s-1][i]} - {1'b0, RW'(dd[s-1]) << K};
      end
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        if (diff[i][RW]) begin
          rem[s][i] <= rem[s-1][i];
          q[s][i]   <= q[s-1][i];
        end else begin
          rem[s][i] <= diff[i][RW-1:0];
          q[s][i]   <= q[s-1][i] | (QB'(1) << K);
        end
      end
      dd[s]   <= dd[s-1];
      side[s] <= side[s-1];
      of[s]   <= of[s-1];
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= vld[s-1];
      end
    end
  end

  assign out_valid = vld[QB];
  assign out_side  = side[QB];
  assign ovf       = of[QB];
  assign quo       = q[QB];
endmodule

// File: rtl/ray_triangle_intersect.sv
// Top level: two-sided ray/triangle intersection pipeline.
//
//   channel   signals                            transfer
//   ------    ---------------------------------  -------------------------
//   input     start, busy, triangle              start && !busy
//   result    result_valid, result               one cycle, cannot stall
//   config    cfg_valid, cfg_ready, cfg_index,   cfg_valid && cfg_ready
//             cfg_data
//
// One triangle per cycle; the one-bit-per-stage divider behind the dot-product
// stages makes up most of the pipeline.
// busy stays low and cfg_ready high; the pipeline never stalls.
// Synchronous reset clears the valid bits and loads the register defaults.
// Config writes must come only while no request is in flight.
`include "assert_macros.svh"

module ray_triangle_intersect (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  rti_pkg::triangle_t              triangle,
  output logic                            result_valid,
  output rti_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rti_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rti_pkg::CW-1:0]          cfg_data
);
  import rti_pkg::*;

  localparam int LAT = QB + 12;

  logic signed [CW-1:0] org [3];
  logic signed [CW-1:0] dir [3];
  logic [CW-1:0]        det_min;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      org[0]  <= '0;
      org[1]  <= '0;
      org[2]  <= '0;
      dir[0]  <= '0;
      dir[1]  <= '0;
      dir[2]  <= DIR_Z_RESET;
      det_min <= DET_MIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ORG_X:   org[0]  <= cfg_data;
        CFG_ORG_Y:   org[1]  <= cfg_data;
        CFG_ORG_Z:   org[2]  <= cfg_data;
        CFG_DIR_X:   dir[0]  <= cfg_data;
        CFG_DIR_Y:   dir[1]  <= cfg_data;
        CFG_DIR_Z:   dir[2]  <= cfg_data;
        CFG_DET_MIN: det_min <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [CW-1:0] va [3];
  logic signed [CW-1:0] vb [3];
  logic signed [CW-1:0] vc [3];

  always_comb begin
    va[0] = triangle.vert_a_x;
    va[1] = triangle.vert_a_y;
    va[2] = triangle.vert_a_z;
    vb[0] = triangle.vert_b_x;
    vb[1] = triangle.vert_b_y;
    vb[2] = triangle.vert_b_z;
    vc[0] = triangle.vert_c_x;
    vc[1] = triangle.vert_c_y;
    vc[2] = triangle.vert_c_z;
  end

  // valid bits for stages 1..10
  logic [9:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[8:0], start && !busy};
    end
  end

  // stage 1..4: edges and origin offset, delayed to meet the products
  logic signed [EW-1:0] e1 [4][3];
  logic signed [EW-1:0] e2 [4][3];
  logic signed [EW-1:0] t0 [4][3];

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      e1[0][c] <= EW'(vb[c]) - EW'(va[c]);
      e2[0][c] <= EW'(vc[c]) - EW'(va[c]);
      t0[0][c] <= EW'(org[c]) - EW'(va[c]);
    end
    for (int d = 1; d < 4; d++) begin
      e1[d] <= e1[d-1];
      e2[d] <= e2[d-1];
      t0[d] <= t0[d-1];
    end
  end

  // cross products P = dir x E2 and Q = T x E1 (T before the sign fix)
  logic signed [CW+EW-1:0] pa [3];
  logic signed [CW+EW-1:0] pb [3];
  logic signed [2*EW-1:0]  qa [3];
  logic signed [2*EW-1:0]  qb [3];
  logic signed [PW-1:0]    pv [3];
  logic signed [QW-1:0]    qv [3];

  for (genvar c = 0; c < 3; c++) begin : g_cross
    localparam int I1 = (c + 1) % 3;
    localparam int I2 = (c + 2) % 3;

    rti_mul #(.AW(CW), .BW(EW)) u_pa (.clk(clk), .a(dir[I1]), .b(e2[0][I2]), .p(pa[c]));
    rti_mul #(.AW(CW), .BW(EW)) u_pb (.clk(clk), .a(dir[I2]), .b(e2[0][I1]), .p(pb[c]));
    rti_mul #(.AW(EW), .BW(EW)) u_qa (.clk(clk), .a(t0[0][I1]), .b(e1[0][I2]), .p(qa[c]));
    rti_mul #(.AW(EW), .BW(EW)) u_qb (.clk(clk), .a(t0[0][I2]), .b(e1[0][I1]), .p(qb[c]));

    always_ff @(posedge clk) begin
      pv[c] <= PW'(pa[c]) - PW'(pb[c]);
      qv[c] <= QW'(qa[c]) - QW'(qb[c]);
    end
  end

  // dot products of the stage 4 operands
  logic signed [EW+PW-1:0] md [3];
  logic signed [EW+PW-1:0] mu [3];
  logic signed [CW+QW-1:0] mv [3];
  logic signed [EW+QW-1:0] mt [3];

  for (genvar c = 0; c < 3; c++) begin : g_dot
    rti_mul #(.AW(EW), .BW(PW)) u_md (.clk(clk), .a(e1[3][c]), .b(pv[c]), .p(md[c]));
    rti_mul #(.AW(EW), .BW(PW)) u_mu (.clk(clk), .a(t0[3][c]), .b(pv[c]), .p(mu[c]));
    rti_mul #(.AW(CW), .BW(QW)) u_mv (.clk(clk), .a(dir[c]), .b(qv[c]), .p(mv[c]));
    rti_mul #(.AW(EW), .BW(QW)) u_mt (.clk(clk), .a(e2[3][c]), .b(qv[c]), .p(mt[c]));
  end

  logic signed [SW-1:0] det7, u7, v7, t7;
  logic signed [SW-1:0] det8, u8, v8, t8;

  always_ff @(posedge clk) begin
    det7 <= SW'(md[0]) + SW'(md[1]) + SW'(md[2]);
    u7   <= SW'(mu[0]) + SW'(mu[1]) + SW'(mu[2]);
    v7   <= SW'(mv[0]) + SW'(mv[1]) + SW'(mv[2]);
    t7   <= SW'(mt[0]) + SW'(mt[1]) + SW'(mt[2]);
  end

  // u, v, t are linear in T, so flipping T flips them with det
  logic flip;
  assign flip = det7[SW-1] || (det7 == '0);

  always_ff @(posedge clk) begin
    det8 <= flip ? -det7 : det7;
    u8   <= flip ? -u7 : u7;
    v8   <= flip ? -v7 : v7;
    t8   <= flip ? -t7 : t7;
  end

  // stage 9: acceptance tests
  logic [SW-1:0]        thr;
  logic signed [SW:0]   uv_sum;
  logic                 hit_c;
  logic                 hit9, tneg9;
  logic [SW-1:0]        d9, tabs9, u9, v9;

  always_comb begin
    thr    = SW'(det_min) << (2 * FB);
    uv_sum = (SW+1)'(u8) + (SW+1)'(v8);
    hit_c  = (det8 != '0) && ($unsigned(det8) >= thr) && !u8[SW-1] && !(det8 < u8) &&
             !v8[SW-1] && !((SW+1)'(det8) < uv_sum);
  end

  always_ff @(posedge clk) begin
    hit9  <= hit_c;
    d9    <= det8;
    tneg9 <= t8[SW-1];
    tabs9 <= t8[SW-1] ? -t8 : t8;
    u9    <= u8;
    v9    <= v8;
  end

  // stage 10: round to nearest, numerator x*2^(F+1) + det over 2*det
  logic [NW-1:0] num10 [3];
  logic [DW-1:0] den10;
  div_side_t     side10;

  always_ff @(posedge clk) begin
    num10[0] <= (NW'(tabs9) << (FB + 1)) + NW'(d9);
    num10[1] <= (NW'(u9) << (FB + 1)) + NW'(d9);
    num10[2] <= (NW'(v9) << (FB + 1)) + NW'(d9);
    den10    <= DW'(d9) << 1;
    side10   <= '{hit: hit9, tneg: tneg9};
  end

  logic          dv_valid;
  div_side_t     dv_side;
  logic          dv_ovf;
  logic [QB-1:0] dv_quo [3];

  rti_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[9]),
    .in_side   (side10),
    .num       (num10),
    .den       (den10),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .ovf       (dv_ovf),
    .quo       (dv_quo)
  );

  // saturate t to the signed coordinate range
  localparam logic [QB-1:0]        HALF     = QB'(1) << (CW - 1);
  localparam logic signed [CW-1:0] DIST_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] DIST_MIN = {1'b1, {(CW-1){1'b0}}};

  logic [CW-1:0]        qlow;
  logic signed [CW-1:0] t_sat;
  result_t              result_next;

  always_comb begin
    qlow = dv_quo[0][CW-1:0];
    if (dv_side.tneg) begin
      t_sat = (dv_ovf || dv_quo[0] > HALF) ? DIST_MIN : -qlow;
    end else begin
      t_sat = (dv_ovf || dv_quo[0] >= HALF) ? DIST_MAX : qlow;
    end
    result_next = '0;
    if (dv_side.hit) begin
      result_next.hit          = 1'b1;
      result_next.hit_distance = t_sat;
      result_next.bary_u       = dv_quo[1][BW-1:0];
      result_next.bary_v       = dv_quo[2][BW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= dv_valid;
    end
  end

  `ASSERT_DELAY(a_latency, clk, rst, start && !busy, LAT, result_valid)
  `ASSERT_IMPLY(a_miss_zero, clk, rst, result_valid && !result.hit, result.hit_distance == '0 && result.bary_u == '0 && result.bary_v == '0)
  `ASSERT_IMPLY(a_bary_range, clk, rst, result_valid && result.hit, result.bary_u <= BARY_ONE && result.bary_v <= BARY_ONE)

endmodule
